// ===== rtl/core/mqrb_pkg.sv =====
// Shared types and constants for the multi-queue ring buffer.
// Holds sizes, controller/datapath command and status structs, byte mask helper.
// No dependencies.
`timescale 1ns / 1ps

package mqrb_pkg;

    localparam int QUEUES        = 4;
    localparam int DEPTH         = 1024;
    localparam int ELEMENT_BYTES = 8;

    localparam int QUEUE_W = 2;
    localparam int DATA_W  = 64;
    localparam int COUNT_W = 4;
    localparam int LEVEL_W = 11;

    localparam int QSEL_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int ADDR_W = QSEL_W + IDX_W;
    localparam int ELEM_W = 8 * ELEMENT_BYTES;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic load;     // capture the accepted word
        logic mem_rd;   // read the addressed slot
        logic commit;   // update queue state and load the result word
        logic clr;      // write zero at the sweep address
    } t_cmd;

    typedef struct packed {
        logic clr_last;
    } t_status;

    // Bytes kept from write data; zero or an oversized count keeps all.
    function automatic logic [DATA_W-1:0] f_byte_mask(input logic [COUNT_W-1:0] cnt);
        logic [DATA_W-1:0] m;
        logic              full;
        m    = '0;
        full = (cnt == '0) || (cnt > COUNT_W'(ELEMENT_BYTES));
        for (int b = 0; b < ELEMENT_BYTES; b++) begin
            if (full || (COUNT_W'(b) < cnt)) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/mqrb_ctrl.sv =====
// Controller of the multi-queue ring buffer: clear sweep, read, commit sequence.
// Drives t_cmd to the datapath and owns both handshakes. Depends on mqrb_pkg.
`timescale 1ns / 1ps

module mqrb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  mqrb_pkg::t_status i_status,
    output mqrb_pkg::t_cmd   o_cmd
);
    import mqrb_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_READ   = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_COMMIT;
            end
            S_COMMIT: begin
                // hold until the result register can take the word
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/core/mqrb_dpath.sv =====
// Datapath of the multi-queue ring buffer: per-queue indices, fill and
// high-water counters, the shared element store and the result registers.
// Depends on mqrb_pkg; driven by mqrb_ctrl.
`timescale 1ns / 1ps

module mqrb_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mqrb_pkg::t_cmd                i_cmd,
    output mqrb_pkg::t_status             o_status,
    input  logic                          i_operation,
    input  logic [mqrb_pkg::QUEUE_W-1:0]  i_queue,
    input  logic [mqrb_pkg::DATA_W-1:0]   i_write_data,
    input  logic [mqrb_pkg::COUNT_W-1:0]  i_byte_count,
    output logic                          o_ok,
    output logic [mqrb_pkg::DATA_W-1:0]   o_read_data,
    output logic [mqrb_pkg::LEVEL_W-1:0]  o_occupancy,
    output logic [mqrb_pkg::LEVEL_W-1:0]  o_max_fill
);
    import mqrb_pkg::*;

    localparam int STORE_DEPTH = QUEUES * DEPTH;

    // captured word
    logic               r_op;
    logic [QUEUE_W-1:0] r_queue;
    logic [DATA_W-1:0]  r_wdata;
    logic [COUNT_W-1:0] r_count;

    // per-queue state
    logic [IDX_W-1:0]  r_wr_idx [QUEUES];
    logic [IDX_W-1:0]  r_rd_idx [QUEUES];
    logic [FILL_W-1:0] r_fill   [QUEUES];
    logic [FILL_W-1:0] r_hw     [QUEUES];

    logic [ELEM_W-1:0] mem [STORE_DEPTH];
    logic [ELEM_W-1:0] r_mem_q;
    logic [ADDR_W-1:0] r_clr_addr;

    logic               r_ok;
    logic [DATA_W-1:0]  r_read_data;
    logic [LEVEL_W-1:0] r_occupancy;
    logic [LEVEL_W-1:0] r_max_fill;

    logic              q_in_range;
    logic [QSEL_W-1:0] qsel;
    logic [IDX_W-1:0]  cur_idx;
    logic [IDX_W-1:0]  slot;
    logic [ADDR_W-1:0] addr;
    logic [FILL_W-1:0] fill_cur;
    logic [FILL_W-1:0] hw_cur;
    logic              acc_ok;
    logic [FILL_W-1:0] fill_new;
    logic [FILL_W-1:0] hw_new;
    logic [ELEM_W-1:0] mask;
    logic [ELEM_W-1:0] merged;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ELEM_W-1:0] mem_wdata;

    assign q_in_range = (32'(r_queue) < QUEUES);
    assign qsel       = QSEL_W'(r_queue);
    assign cur_idx    = (r_op == OP_PUSH) ? r_wr_idx[qsel] : r_rd_idx[qsel];
    assign slot       = (cur_idx == IDX_W'(DEPTH - 1)) ? '0 : cur_idx + 1'b1;
    assign addr       = {qsel, slot};
    assign fill_cur   = r_fill[qsel];
    assign hw_cur     = r_hw[qsel];

    always_comb begin
        acc_ok   = 1'b0;
        fill_new = fill_cur;
        hw_new   = hw_cur;
        if (q_in_range) begin
            if (r_op == OP_PUSH) begin
                acc_ok = (fill_cur < FILL_W'(DEPTH));
                if (acc_ok) begin
                    fill_new = fill_cur + 1'b1;
                    if (fill_new > hw_cur) begin
                        hw_new = fill_new;
                    end
                end
            end else begin
                acc_ok = (fill_cur != '0);
                if (acc_ok) begin
                    fill_new = fill_cur - 1'b1;
                end
            end
        end
    end

    // partial writes keep the old bytes of the slot
    assign mask   = ELEM_W'(f_byte_mask(r_count));
    assign merged = (r_mem_q & ~mask) | (ELEM_W'(r_wdata) & mask);

    assign mem_we    = i_cmd.clr || (i_cmd.commit && acc_ok && (r_op == OP_PUSH));
    assign mem_waddr = i_cmd.clr ? r_clr_addr : addr;
    assign mem_wdata = i_cmd.clr ? '0 : merged;

    assign o_status.clr_last = (r_clr_addr == ADDR_W'(STORE_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_mem_q <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_queue <= i_queue;
            r_wdata <= i_write_data;
            r_count <= i_byte_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < QUEUES; q++) begin
                r_wr_idx[q] <= '0;
                r_rd_idx[q] <= '0;
                r_fill[q]   <= '0;
                r_hw[q]     <= '0;
            end
        end else if (i_cmd.commit && acc_ok) begin
            r_fill[qsel] <= fill_new;
            r_hw[qsel]   <= hw_new;
            if (r_op == OP_PUSH) begin
                r_wr_idx[qsel] <= slot;
            end else begin
                r_rd_idx[qsel] <= slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ok        <= acc_ok;
            r_read_data <= (acc_ok && (r_op == OP_POP)) ? DATA_W'(r_mem_q) : '0;
            r_occupancy <= q_in_range ? LEVEL_W'(fill_new) : '0;
            r_max_fill  <= q_in_range ? LEVEL_W'(hw_new) : '0;
        end
    end

    assign o_ok        = r_ok;
    assign o_read_data = r_read_data;
    assign o_occupancy = r_occupancy;
    assign o_max_fill  = r_max_fill;

endmodule

// ===== rtl/core/multi_queue_ring_buffer_unit.sv =====
// Multi-queue ring buffer: four circular FIFOs over one 4096 x 64 element store.
// After the accepting edge, a store read state and a commit state lead to result valid.
// Each word passes accept, store read and commit before the next is accepted; a result word
// left waiting holds the commit, and with it the next accept.
// Reset: synchronous; queue state clears at once, then a sweep over all 4096 slots zeroes
// the store while input ready stays low. Depends on mqrb_pkg, mqrb_ctrl, mqrb_dpath.
`timescale 1ns / 1ps

module multi_queue_ring_buffer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic [mqrb_pkg::QUEUE_W-1:0]  i_queue,
    input  logic [mqrb_pkg::DATA_W-1:0]   i_write_data,
    input  logic [mqrb_pkg::COUNT_W-1:0]  i_byte_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_ok,
    output logic [mqrb_pkg::DATA_W-1:0]   o_read_data,
    output logic [mqrb_pkg::LEVEL_W-1:0]  o_occupancy,
    output logic [mqrb_pkg::LEVEL_W-1:0]  o_max_fill
);
    import mqrb_pkg::*;

    t_cmd    cmd;
    t_status status;

    mqrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mqrb_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_operation  (i_operation),
        .i_queue      (i_queue),
        .i_write_data (i_write_data),
        .i_byte_count (i_byte_count),
        .o_ok         (o_ok),
        .o_read_data  (o_read_data),
        .o_occupancy  (o_occupancy),
        .o_max_fill   (o_max_fill)
    );

endmodule
